/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the repair block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* hw/rtl/bwr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_pkg
// Types and constants of the binarize and 2x2 repair block.
// ----------------------------------------------------------------------------
package bwr_pkg;

  // Register map of the configuration port
  typedef enum logic [1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam int CFG_DATA_W        = 13;
  localparam int ROW_W             = 12;
  localparam int MAX_HEIGHT        = 4096;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [7:0]  THRESHOLD_RST = 8'd128;
  localparam logic [11:0] WIDTH_RST     = 12'd640;
  localparam logic [12:0] HEIGHT_RST    = 13'd480;

  // Input pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  // Result pixel
  typedef struct packed {
    logic pixel_white;
    logic was_repaired;
    logic end_of_frame;
  } result_t;

  // Classification passed from front to back
  typedef struct packed {
    logic pix_raw;   // thresholded pixel before repair
    logic interior;  // column >= 1 and row >= 1
    logic eof;       // last pixel of the frame
  } item_ctl_t;

endpackage

/* hw/rtl/bwr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_front
// Configuration registers, raster position counters and thresholding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwr_front
  import bwr_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input channel
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  pixel_in_t             pix,
  // push side of the queue
  output logic                  push,
  input  logic                  queue_full,
  output item_ctl_t             ctl,
  output logic [CW-1:0]         col
);

  localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

  logic [7:0]       threshold;
  logic [11:0]      image_width;
  logic [12:0]      image_height;
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;

  logic [WW-1:0]    iw;
  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;
  logic [ROW_W-1:0] row;
  logic             last_col;
  logic             last_row;
  logic [9:0]       sum;
  logic [9:0]       thr3;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data[7:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Last column and last row after clamping the frame size
  assign iw = WW'(image_width);

  always_comb begin
    if (iw < WW'(2))
      col_last = CW'(1);
    else if (iw > WW'(MAX_WIDTH))
      col_last = CW'(MAX_WIDTH - 1);
    else
      col_last = CW'(iw - WW'(1));

    if (image_height < 13'd2)
      row_last = ROW_W'(1);
    else if (image_height > 13'(MAX_HEIGHT))
      row_last = ROW_W'(MAX_HEIGHT - 1);
    else
      row_last = ROW_W'(image_height - 13'd1);
  end

  // Position of this pixel; counters past the end sit on the last place
  assign last_col = (col_cnt >= col_last);
  assign last_row = (row_cnt >= row_last);
  assign col      = last_col ? col_last : col_cnt;
  assign row      = last_row ? row_last : row_cnt;

  // floor(sum/3) >= t  <=>  sum >= 3t
  assign sum  = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
  assign thr3 = {1'b0, threshold, 1'b0} + 10'(threshold);

  assign ctl.pix_raw  = (sum >= thr3);
  assign ctl.interior = (col != '0) && (row != '0);
  assign ctl.eof      = last_col && last_row;

  assign pix_ready = !queue_full;
  assign push      = pix_valid && pix_ready;

  // Raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (push) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col_cnt <= col + CW'(1);
      end
    end
  end

  `ASSERT_NEXT(eof_wraps_counters, clk, rst, push && ctl.eof, (col_cnt == '0) && (row_cnt == '0))

endmodule

/* hw/rtl/bwr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwr_fifo
  import bwr_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign full      = (count == (AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop)      count <= count + (AW + 1)'(1);
      else if (pop && !push) count <= count - (AW + 1)'(1);
    end
  end

  `ASSERT_IMPLY(no_overflow, clk, rst, 1'b1, count <= (AW + 1)'(QUEUE_DEPTH))
  `ASSERT_IMPLY(pop_needs_data, clk, rst, pop, not_empty)

endmodule

/* hw/rtl/bwr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_back
// Line buffer, checkerboard repair of the 2x2 window and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwr_back
  import bwr_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  // queue side
  input  logic          q_valid,
  input  item_ctl_t     q_ctl,
  input  logic [CW-1:0] q_col,
  output logic          q_pop,
  // result channel
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res
);

  // Line buffer of output pixels of the row above
  logic          line_buf [MAX_WIDTH];

  logic          a_valid;
  item_ctl_t     a_ctl;
  logic [CW-1:0] a_col;
  logic          above;
  logic          tl_held;
  logic          left_pix;
  logic          adv_out;
  logic          flip;
  logic          new_pix;

  assign adv_out = a_valid && (!res_valid || res_ready);
  assign q_pop   = q_valid && (!a_valid || adv_out);

  // Stage A: fetch the pixel above while the item waits for the repair stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_pop) begin
      a_valid <= 1'b1;
    end else if (adv_out) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_ctl <= q_ctl;
      a_col <= q_col;
      above <= line_buf[q_col];
    end
    if (adv_out) line_buf[a_col] <= new_pix;
  end

  // Checkerboard: TL == BR, TR == BL, TL != TR
  assign flip    = a_ctl.interior && (tl_held == a_ctl.pix_raw) &&
                   (above == left_pix) && (tl_held != above);
  assign new_pix = a_ctl.pix_raw ^ flip;

  // Window history
  always_ff @(posedge clk) begin
    if (rst) begin
      tl_held  <= 1'b0;
      left_pix <= 1'b0;
    end else if (adv_out) begin
      tl_held  <= above;
      left_pix <= new_pix;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      res.pixel_white  <= new_pix;
      res.was_repaired <= flip;
      res.end_of_frame <= a_ctl.eof;
    end
  end

  `ASSERT_NEXT(stall_holds_fetch, clk, rst, a_valid && !adv_out, a_valid && $stable(a_col) && (above === $past(above)))
  `ASSERT_NEXT(repair_flips, clk, rst, adv_out && flip, res.was_repaired && (res.pixel_white != $past(a_ctl.pix_raw)))

endmodule

/* hw/rtl/binarize_and_well_composed_repair.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binarize_and_well_composed_repair
// Thresholds an RGB raster stream to binary and removes 2x2 checkerboards.
// ----------------------------------------------------------------------------
// One pixel is taken per clock and one result leaves per clock when the sink
// keeps up. The front thresholds the pixel and tracks its raster position, a
// four-entry queue holds it, and the back reads the row above from a one-bit
// line buffer (one read and one write port, read registered), applies the
// repair and holds the result in an output register. The line buffer needs
// no clearing pass: every entry that the repair reads was written in the row
// above. The user must write configuration only when no pixel is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module binarize_and_well_composed_repair
  import bwr_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input channel
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  pixel_in_t             pix,
  // result channel
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int DATA_W = $bits(item_ctl_t) + CW;

  logic              push;
  logic              queue_full;
  item_ctl_t         f_ctl;
  logic [CW-1:0]     f_col;
  logic              q_valid;
  logic              q_pop;
  logic [DATA_W-1:0] q_data;
  item_ctl_t         q_ctl;
  logic [CW-1:0]     q_col;

  bwr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .push       (push),
    .queue_full (queue_full),
    .ctl        (f_ctl),
    .col        (f_col)
  );

  bwr_fifo #(.DATA_W(DATA_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_ctl, f_col}),
    .full      (queue_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign q_ctl = q_data[DATA_W-1:CW];
  assign q_col = q_data[CW-1:0];

  bwr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_col     (q_col),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
